// ----- design/alc_pkg.sv -----
// ----------------------------------------------------------------------------
// alc_pkg: shared types, tables and functions for the round pipeline.
// Holds the S-box tables, field multiplies and round step helpers.
// ----------------------------------------------------------------------------
package alc_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned RoundW    = 4;

  typedef logic [127:0] block_t;

  typedef enum logic {
    OpEncrypt = 1'b0,
    OpDecrypt = 1'b1
  } op_e;

  typedef enum logic {
    CfgKeyLow  = 1'b0,
    CfgKeyHigh = 1'b1
  } cfg_idx_e;

  localparam logic [7:0] FwdBox [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] InvBox [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  localparam logic [3:0] FwdPerm [16] = '{
    4'd0, 4'd5, 4'd10, 4'd15, 4'd4, 4'd9, 4'd14, 4'd3,
    4'd8, 4'd13, 4'd2, 4'd7, 4'd12, 4'd1, 4'd6, 4'd11
  };
  localparam logic [3:0] InvPerm [16] = '{
    4'd0, 4'd13, 4'd10, 4'd7, 4'd4, 4'd1, 4'd14, 4'd11,
    4'd8, 4'd5, 4'd2, 4'd15, 4'd12, 4'd9, 4'd6, 4'd3
  };

  localparam logic [7:0] GfPoly = 8'h1b;
  localparam logic [7:0] Tweak  = 8'h11;

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return x[7] ? ({x[6:0], 1'b0} ^ GfPoly) : {x[6:0], 1'b0};
  endfunction

  function automatic block_t round_key(input block_t key, input logic [RoundW-1:0] r);
    block_t     rk;
    logic [7:0] tw;
    logic [3:0] src;
    tw = 8'(r * Tweak);
    for (int i = 0; i < 16; i++) begin
      src = 4'(i) + r;
      rk[8*i +: 8] = key[8*src +: 8] ^ tw;
    end
    return rk;
  endfunction

  function automatic block_t sub_fwd(input block_t b);
    block_t t;
    for (int i = 0; i < 16; i++) t[8*i +: 8] = FwdBox[b[8*i +: 8]];
    return t;
  endfunction

  function automatic block_t sub_inv(input block_t b);
    block_t t;
    for (int i = 0; i < 16; i++) t[8*i +: 8] = InvBox[b[8*i +: 8]];
    return t;
  endfunction

  function automatic block_t perm_fwd(input block_t b);
    block_t t;
    for (int i = 0; i < 16; i++) t[8*i +: 8] = b[8*FwdPerm[i] +: 8];
    return t;
  endfunction

  function automatic block_t perm_inv(input block_t b);
    block_t t;
    for (int i = 0; i < 16; i++) t[8*i +: 8] = b[8*InvPerm[i] +: 8];
    return t;
  endfunction

  // Column j is bytes j, 4+j, 8+j, 12+j.
  function automatic block_t mix_fwd(input block_t b);
    block_t     t;
    logic [7:0] a [4];
    for (int j = 0; j < 4; j++) begin
      for (int k = 0; k < 4; k++) a[k] = b[8*(4*k+j) +: 8];
      for (int i = 0; i < 4; i++) begin
        t[8*(4*i+j) +: 8] = xtime(a[i]) ^ xtime(a[(i+1)%4]) ^ a[(i+1)%4]
                          ^ a[(i+2)%4] ^ a[(i+3)%4];
      end
    end
    return t;
  endfunction

  function automatic block_t mix_inv(input block_t b);
    block_t     t;
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    for (int j = 0; j < 4; j++) begin
      for (int k = 0; k < 4; k++) begin
        a[k]  = b[8*(4*k+j) +: 8];
        x2[k] = xtime(a[k]);
        x4[k] = xtime(x2[k]);
        x8[k] = xtime(x4[k]);
      end
      for (int i = 0; i < 4; i++) begin
        t[8*(4*i+j) +: 8] = (x8[i] ^ x4[i] ^ x2[i])
                          ^ (x8[(i+1)%4] ^ x2[(i+1)%4] ^ a[(i+1)%4])
                          ^ (x8[(i+2)%4] ^ x4[(i+2)%4] ^ a[(i+2)%4])
                          ^ (x8[(i+3)%4] ^ a[(i+3)%4]);
      end
    end
    return t;
  endfunction

endpackage

// ----- design/alc_round.sv -----
// ----------------------------------------------------------------------------
// alc_round: one registered round stage of the cipher pipeline.
// Applies an encrypt or decrypt round step chosen by the item's operation.
// ----------------------------------------------------------------------------
module alc_round import alc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic              op_i,
  input  block_t            data_i,
  input  block_t            key_i,
  input  logic [RoundW-1:0] round_i,
  input  logic              last_i,
  output logic              valid_o,
  output logic              op_o,
  output block_t            data_o
);

  logic   valid_q;
  logic   op_q;
  block_t data_q;
  block_t data_d;
  block_t s_enc;
  block_t s_dec;
  block_t rk_enc;
  block_t rk_dec;

  // Encrypt stage r: sub, shift, mix (not last), add key r.
  // Decrypt stage r: add key 10-r, then inverse mix, shift and sub (not last).
  always_comb begin
    rk_enc = round_key(key_i, round_i);
    rk_dec = round_key(key_i, RoundW'(NumRounds) - round_i);
    s_enc  = perm_fwd(sub_fwd(data_i));
    if (!last_i) begin
      s_enc = mix_fwd(s_enc);
    end
    s_enc  = s_enc ^ rk_enc;
    s_dec  = data_i ^ rk_dec;
    if (!last_i) begin
      s_dec = sub_inv(perm_inv(mix_inv(s_dec)));
    end
    data_d = (op_i == OpDecrypt) ? s_dec : s_enc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op_q   <= op_i;
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign op_o    = op_q;
  assign data_o  = data_q;

endmodule

// ----- design/aes_like_block_cipher.sv -----
// ----------------------------------------------------------------------------
// aes_like_block_cipher: ten-round AES-like block cipher, encrypt and decrypt.
// Fully unrolled pipeline, one round per register stage.
// ----------------------------------------------------------------------------
//  channel  | dir | fields
//  s_axis   | in  | tdata: block_low, block_high; tuser: operation
//  m_axis   | out | tdata: result_low, result_high
//  cfg      | in  | key_low (0), key_high (1)
//
// One item per cycle unless the pipeline holds; key whitening plus ten round stages.
// Reset clears all stage valid bits and the key to zero.
// The whole pipeline holds when the output stage is full and not taken.
module aes_like_block_cipher import alc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // block_low, block_high
  input  logic         s_axis_tuser,   // operation
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // result_low, result_high
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [63:0]  cfg_data_i
);

  logic [63:0] key_lo_q;
  logic [63:0] key_hi_q;
  block_t      key;
  logic        en;

  logic        v   [NumRounds+1];
  logic        op  [NumRounds+1];
  block_t      dat [NumRounds+1];

  logic        v0_q;
  logic        op0_q;
  block_t      dat0_q;

  assign key           = {key_hi_q, key_lo_q};
  assign en            = m_axis_tready || !v[NumRounds];
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_lo_q <= '0;
      key_hi_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgKeyLow:  key_lo_q <= cfg_data_i;
        CfgKeyHigh: key_hi_q <= cfg_data_i;
        default:    key_lo_q <= key_lo_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= s_axis_tvalid;
    end
  end

  // Whitening: key 0 for encrypt, key 10 for decrypt (with inverse shift, sub).
  always_ff @(posedge clk_i) begin
    if (en) begin
      op0_q  <= s_axis_tuser;
      dat0_q <= (s_axis_tuser == OpDecrypt)
              ? sub_inv(perm_inv(s_axis_tdata ^ round_key(key, RoundW'(NumRounds))))
              : (s_axis_tdata ^ round_key(key, '0));
    end
  end

  assign v[0]   = v0_q;
  assign op[0]  = op0_q;
  assign dat[0] = dat0_q;

  for (genvar g = 1; g <= NumRounds; g++) begin : g_rnd
    alc_round u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (v[g-1]),
      .op_i    (op[g-1]),
      .data_i  (dat[g-1]),
      .key_i   (key),
      .round_i (RoundW'(g)),
      .last_i  (g == NumRounds),
      .valid_o (v[g]),
      .op_o    (op[g]),
      .data_o  (dat[g])
    );
  end

  assign m_axis_tvalid = v[NumRounds];
  assign m_axis_tdata  = dat[NumRounds];

endmodule
